/* sv/pgl_pkg.sv */
// ----------------------------------------------------------------------------
// pgl_pkg
// Shared types and constants for the premultiplied gamma lookup pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pgl_pkg;

   localparam logic       PGL_OP_PIXEL      = 1'b0;
   localparam logic       PGL_OP_WRITE      = 1'b1;
   localparam logic [7:0] PGL_ALPHA_OPAQUE  = 8'hff;
   localparam logic [7:0] PGL_BYTE_MAX      = 8'hff;
   localparam int         PGL_RECIP_CAP     = 32767;
   localparam int         PGL_RECIP_NUM     = 65536;
   localparam int         PGL_RECIP_W       = 15;

   typedef struct packed {
      logic        opcode;
      logic [31:0] pixel_in;
      logic        last_pixel;
      logic [7:0]  table_index;
      logic [7:0]  red_value;
      logic [7:0]  green_value;
      logic [7:0]  blue_value;
   } pgl_req_type;

   typedef struct packed {
      logic [31:0] pixel_out;
      logic        last_out;
   } pgl_rsp_type;

   typedef struct packed {
      logic en2;
      logic en3;
      logic wr_en;
      logic opaque1;
      logic opaque3;
   } pgl_ctl_type;

endpackage

`default_nettype wire

/* sv/pgl_chan.sv */
// ----------------------------------------------------------------------------
// pgl_chan
// One color channel: index calculation, gamma table and rescaling by alpha.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgl_chan (
   input  wire logic                           clock,
   input  wire pgl_pkg::pgl_ctl_type           ctl,
   input  wire logic [7:0]                     c1,
   input  wire logic [7:0]                     alpha1,
   input  wire logic [pgl_pkg::PGL_RECIP_W-1:0] recip1,
   input  wire logic [7:0]                     alpha3,
   input  wire logic [7:0]                     wr_index,
   input  wire logic [7:0]                     wr_value,
   output logic      [7:0]                     chan_out
);
   import pgl_pkg::*;

   logic [22:0] prod1;
   logic        over1;
   logic [7:0]  idx_in;
   logic [7:0]  diff_in;
   logic [7:0]  idx_ff;
   logic [7:0]  diff2_ff;
   logic [7:0]  diff3_ff;
   logic [7:0]  lut_ff;
   logic [7:0]  lut_mem [256];
   logic [8:0]  scale3;
   logic [16:0] prod3;
   logic [8:0]  sum3;
   logic [7:0]  sat3;

   assign prod1   = 23'(recip1) * 23'(c1);
   assign over1   = c1 > alpha1;
   assign idx_in  = ctl.opaque1 ? c1 : (over1 ? PGL_BYTE_MAX : prod1[15:8]);
   assign diff_in = over1 ? 8'(c1 - alpha1) : 8'd0;

   always_ff @(posedge clock) begin
      if (ctl.en2) begin
         idx_ff   <= idx_in;
         diff2_ff <= diff_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         lut_mem[wr_index] <= wr_value;
      end
      if (ctl.en3) begin
         lut_ff   <= lut_mem[idx_ff];
         diff3_ff <= diff2_ff;
      end
   end

   assign scale3   = 9'(alpha3) + 9'(alpha3[7]);
   assign prod3    = 17'(lut_ff) * 17'(scale3);
   assign sum3     = 9'(prod3[15:8]) + 9'(diff3_ff);
   assign sat3     = sum3[8] ? PGL_BYTE_MAX : sum3[7:0];
   assign chan_out = ctl.opaque3 ? lut_ff : sat3;

endmodule

`default_nettype wire

/* sv/premultiplied_gamma_lut.sv */
// ----------------------------------------------------------------------------
// premultiplied_gamma_lut
// Each accepted word passes through the stage 1, 2 and 3 registers and the
// output register. Throughput: one word per cycle when not stalled; each
// gamma table has one write and one read port, and a table write takes one
// slot without giving a result. Reset clears the stage valid bits only; the
// gamma tables hold no value until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module premultiplied_gamma_lut (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire pgl_pkg::pgl_req_type req_word,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output pgl_pkg::pgl_rsp_type      rsp_word
);
   import pgl_pkg::*;

   logic [PGL_RECIP_W-1:0] recip_rom [256];

   for (genvar g = 0; g < 256; g++) begin : g_recip
      localparam int Quot   = PGL_RECIP_NUM / ((g == 0) ? 1 : g);
      localparam int Capped = ((g == 0) || (Quot > PGL_RECIP_CAP)) ? PGL_RECIP_CAP : Quot;
      assign recip_rom[g] = PGL_RECIP_W'(Capped);
   end

   logic                   ready1, ready2, ready3, ready4;
   logic                   s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   pgl_req_type            s1_word_ff;
   logic [PGL_RECIP_W-1:0] s1_recip_ff;
   logic                   s1_opaque, s1_zero;
   logic                   s2_op_ff, s2_last_ff, s2_opaque_ff, s2_zero_ff;
   logic [7:0]             s2_alpha_ff, s2_index_ff, s2_red_ff, s2_green_ff, s2_blue_ff;
   logic                   s3_op_ff, s3_last_ff, s3_opaque_ff, s3_zero_ff;
   logic [7:0]             s3_alpha_ff;
   logic [7:0]             red3, green3, blue3;
   pgl_ctl_type            ctl;
   pgl_rsp_type            rsp_word_in;
   pgl_rsp_type            rsp_word_ff;

   assign ready4    = !rsp_valid_ff || !rsp_stall;
   assign ready3    = !s3_valid_ff || ready4;
   assign ready2    = !s2_valid_ff || ready3;
   assign ready1    = !s1_valid_ff || ready2;
   assign req_stall = !ready1;

   assign s1_opaque = s1_word_ff.pixel_in[31:24] == PGL_ALPHA_OPAQUE;
   assign s1_zero   = s1_word_ff.pixel_in == 32'd0;

   assign ctl.en2     = ready2;
   assign ctl.en3     = ready3;
   assign ctl.wr_en   = ready3 && s2_valid_ff && (s2_op_ff == PGL_OP_WRITE);
   assign ctl.opaque1 = s1_opaque;
   assign ctl.opaque3 = s3_opaque_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ready1) begin
            s1_valid_ff <= req_valid;
         end
         if (ready2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (ready3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (ready4) begin
            rsp_valid_ff <= s3_valid_ff && (s3_op_ff == PGL_OP_PIXEL);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         s1_word_ff  <= req_word;
         s1_recip_ff <= recip_rom[req_word.pixel_in[31:24]];
      end
      if (ready2) begin
         s2_op_ff     <= s1_word_ff.opcode;
         s2_last_ff   <= s1_word_ff.last_pixel;
         s2_opaque_ff <= s1_opaque;
         s2_zero_ff   <= s1_zero;
         s2_alpha_ff  <= s1_word_ff.pixel_in[31:24];
         s2_index_ff  <= s1_word_ff.table_index;
         s2_red_ff    <= s1_word_ff.red_value;
         s2_green_ff  <= s1_word_ff.green_value;
         s2_blue_ff   <= s1_word_ff.blue_value;
      end
      if (ready3) begin
         s3_op_ff     <= s2_op_ff;
         s3_last_ff   <= s2_last_ff;
         s3_opaque_ff <= s2_opaque_ff;
         s3_zero_ff   <= s2_zero_ff;
         s3_alpha_ff  <= s2_alpha_ff;
      end
      if (ready4) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   pgl_chan u_red (
      .clock    (clock),
      .ctl      (ctl),
      .c1       (s1_word_ff.pixel_in[23:16]),
      .alpha1   (s1_word_ff.pixel_in[31:24]),
      .recip1   (s1_recip_ff),
      .alpha3   (s3_alpha_ff),
      .wr_index (s2_index_ff),
      .wr_value (s2_red_ff),
      .chan_out (red3)
   );

   pgl_chan u_green (
      .clock    (clock),
      .ctl      (ctl),
      .c1       (s1_word_ff.pixel_in[15:8]),
      .alpha1   (s1_word_ff.pixel_in[31:24]),
      .recip1   (s1_recip_ff),
      .alpha3   (s3_alpha_ff),
      .wr_index (s2_index_ff),
      .wr_value (s2_green_ff),
      .chan_out (green3)
   );

   pgl_chan u_blue (
      .clock    (clock),
      .ctl      (ctl),
      .c1       (s1_word_ff.pixel_in[7:0]),
      .alpha1   (s1_word_ff.pixel_in[31:24]),
      .recip1   (s1_recip_ff),
      .alpha3   (s3_alpha_ff),
      .wr_index (s2_index_ff),
      .wr_value (s2_blue_ff),
      .chan_out (blue3)
   );

   assign rsp_word_in.pixel_out = s3_zero_ff ? 32'd0 : {s3_alpha_ff, red3, green3, blue3};
   assign rsp_word_in.last_out  = s3_last_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

/* sv/pgl_checker.sv */
// ----------------------------------------------------------------------------
// pgl_checker
// Port-level checks for the premultiplied gamma lookup pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgl_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire pgl_pkg::pgl_req_type req_word,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire pgl_pkg::pgl_rsp_type rsp_word
);
   import pgl_pkg::*;

   // No word is ever left in the output register across reset.
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // With an empty output stage the whole pipeline can advance.
   a_no_false_stall : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while output stage is empty");

   // A zero pixel comes out as a zero result word when the output is not stalled.
   a_zero_pass : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_word.opcode == PGL_OP_PIXEL) &&
       (req_word.pixel_in == 32'd0))
      ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_valid && (rsp_word.pixel_out == 32'd0))
      else $error("zero pixel not passed through with expected latency");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed or dropped");

endmodule

bind premultiplied_gamma_lut pgl_checker u_pgl_checker (.*);

`default_nettype wire

/* sim/gamma_lut_checker.sv */
// ----------------------------------------------------------------------------
// gamma_lut_checker
// Watches the request and response sides of the premultiplied gamma lookup
// block. Table-write words update a private copy of the three gamma tables;
// pixel words are turned into expected result words, which are compared in
// order with the words the block delivers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gamma_lut_checker (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire pgl_pkg::pgl_req_type req_word,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire pgl_pkg::pgl_rsp_type rsp_word,
   output int                        mismatch_count,
   output int                        pending_count
);
   import pgl_pkg::*;

   localparam int REPORT_LIMIT = 10;

   logic [7:0]  red_lut   [256];
   logic [7:0]  green_lut [256];
   logic [7:0]  blue_lut  [256];
   pgl_rsp_type pending_pixels [$];
   pgl_rsp_type expected_pixel;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   function automatic logic [14:0] reciprocal(input logic [7:0] a);
      int unsigned q;
      if (a == 8'd0) return 15'(PGL_RECIP_CAP);
      q = PGL_RECIP_NUM / int'(a);
      if (q > PGL_RECIP_CAP) q = PGL_RECIP_CAP;
      return 15'(q);
   endfunction

   function automatic logic [7:0] lut_index(input logic [7:0] c, input logic [7:0] a);
      logic [31:0] prod;
      prod = 32'(reciprocal(a)) * 32'(c);
      if (c > a) return PGL_BYTE_MAX;
      return prod[15:8];
   endfunction

   function automatic logic [7:0] rescale(input logic [7:0] t, input logic [7:0] c,
                                          input logic [7:0] a);
      logic [31:0] prod;
      logic [31:0] sum;
      prod = 32'(t) * (32'(a) + 32'(a >> 7));
      sum  = 32'(prod[15:8]) + ((c > a) ? 32'(c) - 32'(a) : 32'd0);
      return (sum > 32'(PGL_BYTE_MAX)) ? PGL_BYTE_MAX : sum[7:0];
   endfunction

   function automatic pgl_rsp_type gamma_pixel(input pgl_req_type w);
      pgl_rsp_type r;
      logic [7:0]  a;
      logic [7:0]  cr;
      logic [7:0]  cg;
      logic [7:0]  cb;
      a  = w.pixel_in[31:24];
      cr = w.pixel_in[23:16];
      cg = w.pixel_in[15:8];
      cb = w.pixel_in[7:0];
      r.last_out = w.last_pixel;
      if (a == PGL_ALPHA_OPAQUE) begin
         r.pixel_out = {a, red_lut[cr], green_lut[cg], blue_lut[cb]};
      end else if (w.pixel_in == 32'd0) begin
         r.pixel_out = 32'd0;
      end else begin
         r.pixel_out = {a,
                        rescale(red_lut[lut_index(cr, a)], cr, a),
                        rescale(green_lut[lut_index(cg, a)], cg, a),
                        rescale(blue_lut[lut_index(cb, a)], cb, a)};
      end
      return r;
   endfunction

   task automatic report(input string msg);
      if (mismatch_count < REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               report($sformatf("unexpected word pixel_out=%08h last_out=%0b",
                                rsp_word.pixel_out, rsp_word.last_out));
            end else begin
               expected_pixel = pending_pixels.pop_front();
               if (rsp_word.pixel_out !== expected_pixel.pixel_out ||
                   rsp_word.last_out !== expected_pixel.last_out) begin
                  report($sformatf("expected pixel_out=%08h last_out=%0b, got %08h %0b",
                                   expected_pixel.pixel_out, expected_pixel.last_out,
                                   rsp_word.pixel_out, rsp_word.last_out));
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_word.opcode == PGL_OP_WRITE) begin
               red_lut[req_word.table_index]   = req_word.red_value;
               green_lut[req_word.table_index] = req_word.green_value;
               blue_lut[req_word.table_index]  = req_word.blue_value;
            end else begin
               pending_pixels.push_back(gamma_pixel(req_word));
            end
         end
         pending_count = pending_pixels.size();
      end
   end

endmodule

/* sim/premultiplied_gamma_lut_tb.sv */
// ----------------------------------------------------------------------------
// premultiplied_gamma_lut_tb
// Loads all three gamma tables, runs a directed set of pixel and table-write
// words, then random words under several idle and stall patterns, including
// a long output hold-off that backs the pipeline up to its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module premultiplied_gamma_lut_tb;
   import pgl_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int HOLD_OFF       = 300;
   localparam int PHASE_WORDS    = 330;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   pgl_req_type req_word;
   logic        rsp_valid;
   logic        rsp_stall;
   pgl_rsp_type rsp_word;
   int          mismatch_count;
   int          pending_count;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          hold_left      = 0;
   int          quiet_cycles   = 0;
   int          send_pcts [4]  = '{0, 88, 0, 23};
   int          recv_pcts [4]  = '{0, 0, 88, 23};

   premultiplied_gamma_lut dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   gamma_lut_checker pixel_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word       (rsp_word),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(0, 99) < recv_stall_pct);
         end
      end
   end

   function automatic pgl_req_type pixel_word(input logic [31:0] p, input logic last);
      pgl_req_type w;
      w = '0;
      w.opcode     = PGL_OP_PIXEL;
      w.pixel_in   = p;
      w.last_pixel = last;
      return w;
   endfunction

   function automatic pgl_req_type table_word(input logic [7:0] idx, input logic [7:0] r,
                                              input logic [7:0] g, input logic [7:0] b);
      pgl_req_type w;
      w = '0;
      w.opcode      = PGL_OP_WRITE;
      w.table_index = idx;
      w.red_value   = r;
      w.green_value = g;
      w.blue_value  = b;
      return w;
   endfunction

   function automatic pgl_req_type random_word();
      pgl_req_type w;
      logic [7:0]  a;
      int          kind;
      w.opcode      = ($urandom_range(0, 99) < 15) ? PGL_OP_WRITE : PGL_OP_PIXEL;
      w.pixel_in    = $urandom;
      w.last_pixel  = ($urandom_range(0, 7) == 0);
      w.table_index = $urandom_range(0, 255);
      w.red_value   = $urandom_range(0, 255);
      w.green_value = $urandom_range(0, 255);
      w.blue_value  = $urandom_range(0, 255);
      if (w.opcode == PGL_OP_PIXEL) begin
         kind = $urandom_range(0, 9);
         a    = $urandom_range(0, 255);
         case (kind)
            0: w.pixel_in[31:24] = PGL_ALPHA_OPAQUE;
            1: w.pixel_in = 32'd0;
            2: w.pixel_in[31:24] = 8'd0;
            3: w.pixel_in = $urandom;
            default: begin
               w.pixel_in = {a, 8'($urandom_range(0, a)), 8'($urandom_range(0, a)),
                             8'($urandom_range(0, a))};
            end
         endcase
      end
      return w;
   endfunction

   task automatic send_word(input pgl_req_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_word  = w;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct, input int hold);
      req_valid = 1'b0;
      @(posedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      hold_left      = hold;
      @(negedge clock);
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < 256; i++) begin
         send_word(table_word(8'(i), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
      end

      send_word(table_word(8'h00, 8'hff, 8'h00, 8'hff));
      send_word(table_word(8'hff, 8'h00, 8'hff, 8'h00));
      send_word(pixel_word(32'hffffffff, 1'b1));
      send_word(pixel_word(32'hff000000, 1'b0));
      send_word(pixel_word(32'h00000000, 1'b1));
      send_word(pixel_word(32'h00ffffff, 1'b0));
      send_word(pixel_word(32'h00000001, 1'b0));
      send_word(pixel_word(32'h01010101, 1'b0));
      send_word(pixel_word(32'h01000000, 1'b1));
      send_word(pixel_word(32'h03030201, 1'b0));
      send_word(pixel_word(32'h7f7f7f7f, 1'b0));
      send_word(pixel_word(32'h80808080, 1'b0));
      send_word(pixel_word(32'h80ff4000, 1'b1));
      send_word(pixel_word(32'hfefefefe, 1'b0));
      send_word(pixel_word(32'hfe00fffe, 1'b0));
      send_word(table_word(8'h7f, 8'h12, 8'h34, 8'h56));
      send_word(pixel_word(32'hff7f7f7f, 1'b0));
      send_word(table_word(8'h80, 8'hff, 8'hff, 8'hff));
      send_word(pixel_word(32'h80808080, 1'b1));
      send_word(pixel_word(32'h20102010, 1'b0));
      send_word(pixel_word(32'hff00ff00, 1'b1));
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         set_idling(send_pcts[ph], recv_pcts[ph], 0);
         repeat (PHASE_WORDS) send_word(random_word());
         wait_drained();
      end

      set_idling(0, 0, HOLD_OFF);
      repeat (60) send_word(random_word());
      wait_drained();

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
